[src/skvt_pkg.sv]
// skvt_pkg: shared types and codes for the sorted key/handle table.
// Used by skvt_cell and sorted_key_value_table_unit; no dependencies.
package skvt_pkg;

    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int RANK_W   = 6;
    localparam int STATUS_W = 3;
    localparam int ENTRIES_W = 7;

    // command codes carried in the low bits of an input beat
    typedef enum logic [1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_RANK   = 2'd3
    } cmd_t;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ABSENT  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_PRESENT = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_RANK    = 3'd4;

    // shift command broadcast to every cell in the update cycle
    typedef struct packed {
        logic ins;   // open a gap at the insert point and drop the new entry in
        logic rem;   // close the gap at the matching entry
    } cell_ctrl_t;

endpackage

[src/skvt_cell.sv]
// skvt_cell: one slot of the sorted table; holds a key and handle,
// compares against the incoming key and shifts to/from its neighbors. Uses skvt_pkg.
module skvt_cell #(
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // compare phase, taken on the accepted input beat
    input  logic                          cmp_en,
    input  logic [skvt_pkg::KEY_W-1:0]    cmp_key,
    input  logic [skvt_pkg::RANK_W-1:0]   cmp_rank,
    input  logic [CNT_W-1:0]              count,
    // update phase
    input  skvt_pkg::cell_ctrl_t          ctrl,
    input  logic [skvt_pkg::KEY_W-1:0]    new_key,
    input  logic [skvt_pkg::HANDLE_W-1:0] new_handle,
    input  logic                          left_lt,
    input  logic [skvt_pkg::KEY_W-1:0]    left_key,
    input  logic [skvt_pkg::HANDLE_W-1:0] left_handle,
    input  logic [skvt_pkg::KEY_W-1:0]    right_key,
    input  logic [skvt_pkg::HANDLE_W-1:0] right_handle,
    // state and flags seen by neighbors and the top level
    output logic                          lt,
    output logic                          eq,
    output logic                          rsel,
    output logic [skvt_pkg::KEY_W-1:0]    key,
    output logic [skvt_pkg::HANDLE_W-1:0] handle
);
    import skvt_pkg::*;

    logic                occ;
    logic                lt_reg, eq_reg, rsel_reg;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;

    // slot holds a live entry when it sits below the count
    assign occ = (CNT_W'(IDX) < count);

    // compare flags, registered on the accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg   <= 1'b0;
            eq_reg   <= 1'b0;
            rsel_reg <= 1'b0;
        end
        else if (cmp_en)
        begin
            lt_reg   <= occ && ($signed(key_reg) < $signed(cmp_key));
            eq_reg   <= occ && (key_reg == cmp_key);
            rsel_reg <= occ && (32'(IDX) == 32'(cmp_rank));
        end
    end

    // shift network: slots at or above the insert/remove point move
    always_comb
    begin
        key_next    = key_reg;
        handle_next = handle_reg;
        if (ctrl.ins && !lt_reg)
        begin
            if (left_lt)
            begin
                key_next    = new_key;
                handle_next = new_handle;
            end
            else
            begin
                key_next    = left_key;
                handle_next = left_handle;
            end
        end
        else if (ctrl.rem && !lt_reg)
        begin
            key_next    = right_key;
            handle_next = right_handle;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        handle_reg <= handle_next;
    end

    assign lt     = lt_reg;
    assign eq     = eq_reg;
    assign rsel   = rsel_reg;
    assign key    = key_reg;
    assign handle = handle_reg;

endmodule

[src/sorted_key_value_table_unit.sv]
// sorted_key_value_table_unit: a sorted key-to-handle table built from a row
// of skvt_cell slots. Depends on skvt_pkg and skvt_cell.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready/s_tdata; each beat is one command
//   (find, insert, remove, read at rank). Every beat yields exactly one result
//   beat on m_tvalid/m_tready/m_tdata with a status, key, handle and the
//   number of entries left after the command.
//   Timing: on the accepting edge every cell compares its key with the input
//   key in parallel; then, in S_APPLY and once the output register is free,
//   the row shifts in one step (insert or remove) and the result is loaded
//   into the output register, which drives m_tvalid. The rate is set by this
//   compare-then-shift pair: s_tready is high only in S_IDLE, so a new
//   command is not taken until the last one has left S_APPLY.
//   The output register is separate: the next command is accepted while a
//   result still waits. If the receiver stalls, the update step holds until
//   the output register is free, and no further input is taken meanwhile.
//   Reset clears the entry count and the handshake state; table contents
//   are not cleared and need no clearing pass, since only slots below the
//   count are ever read.
module sorted_key_value_table_unit #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // cmd[1:0], lookup_key[33:2], entry_handle[65:34], rank[71:66]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // status[2:0], key_out[34:3], handle_out[66:35], entries_now[73:67], zeros
);
    import skvt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                out_valid_reg;
    logic [79:0]         out_data_reg;
    cmd_t                cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [HANDLE_W-1:0] handle_reg;

    logic                s_accept, apply_go;
    logic [KEY_W-1:0]    in_key;
    logic [HANDLE_W-1:0] in_handle;
    logic [RANK_W-1:0]   in_rank;
    cell_ctrl_t          ctrl;

    logic [CAPACITY-1:0] lt_v, eq_v, rsel_v;
    logic [KEY_W-1:0]    cell_key    [CAPACITY];
    logic [HANDLE_W-1:0] cell_handle [CAPACITY];

    logic                hit, rank_ok, full, ins_ok, rem_ok;
    logic [KEY_W-1:0]    sel_key;
    logic [HANDLE_W-1:0] sel_handle;
    logic [STATUS_W-1:0] status;
    logic                give_data;

    // input beat fields
    assign in_key    = s_tdata[33:2];
    assign in_handle = s_tdata[65:34];
    assign in_rank   = s_tdata[71:66];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign apply_go = (state_reg == S_APPLY) && (!out_valid_reg || m_tready);

    // command capture
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            cmd_reg    <= cmd_t'(s_tdata[1:0]);
            key_reg    <= in_key;
            handle_reg <= in_handle;
        end
    end

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                left_lt;
        logic [KEY_W-1:0]    left_key, right_key;
        logic [HANDLE_W-1:0] left_handle, right_handle;

        if (i == 0)
        begin : g_first
            assign left_lt     = 1'b1;
            assign left_key    = key_reg;
            assign left_handle = handle_reg;
        end
        else
        begin : g_mid
            assign left_lt     = lt_v[i-1];
            assign left_key    = cell_key[i-1];
            assign left_handle = cell_handle[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_key    = cell_key[i];
            assign right_handle = cell_handle[i];
        end
        else
        begin : g_inner
            assign right_key    = cell_key[i+1];
            assign right_handle = cell_handle[i+1];
        end

        skvt_cell #(
            .CNT_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmp_en       (s_accept),
            .cmp_key      (in_key),
            .cmp_rank     (in_rank),
            .count        (count_reg),
            .ctrl         (ctrl),
            .new_key      (key_reg),
            .new_handle   (handle_reg),
            .left_lt      (left_lt),
            .left_key     (left_key),
            .left_handle  (left_handle),
            .right_key    (right_key),
            .right_handle (right_handle),
            .lt           (lt_v[i]),
            .eq           (eq_v[i]),
            .rsel         (rsel_v[i]),
            .key          (cell_key[i]),
            .handle       (cell_handle[i])
        );
    end

    // gather: at most one cell is selected, so an AND-OR picks its entry
    always_comb
    begin
        sel_key    = '0;
        sel_handle = '0;
        for (int j = 0; j < CAPACITY; j++)
        begin
            if ((cmd_reg == CMD_RANK) ? rsel_v[j] : eq_v[j])
            begin
                sel_key    = sel_key | cell_key[j];
                sel_handle = sel_handle | cell_handle[j];
            end
        end
    end

    assign hit     = |eq_v;
    assign rank_ok = |rsel_v;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign ins_ok  = (cmd_reg == CMD_INSERT) && !hit && !full;
    assign rem_ok  = (cmd_reg == CMD_REMOVE) && hit;

    assign ctrl.ins = apply_go && ins_ok;
    assign ctrl.rem = apply_go && rem_ok;

    // status decode
    always_comb
    begin
        status = STAT_OK;
        unique case (cmd_reg)
            CMD_FIND:   status = hit ? STAT_OK : STAT_ABSENT;
            CMD_INSERT: status = hit ? STAT_PRESENT : (full ? STAT_FULL : STAT_OK);
            CMD_REMOVE: status = hit ? STAT_OK : STAT_ABSENT;
            CMD_RANK:   status = rank_ok ? STAT_OK : STAT_RANK;
            default:    status = STAT_OK;
        endcase
    end

    assign give_data = (status == STAT_OK) && (cmd_reg != CMD_INSERT);

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
            count_next = CNT_W'(count_reg + 1'b1);
        else if (ctrl.rem)
            count_next = CNT_W'(count_reg - 1'b1);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_accept) state_next = S_APPLY;
            S_APPLY: if (apply_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (apply_go)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (apply_go)
        begin
            out_data_reg <= {6'd0,
                             ENTRIES_W'(count_next),
                             give_data ? sel_handle : {HANDLE_W{1'b0}},
                             give_data ? sel_key : {KEY_W{1'b0}},
                             status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("insert did not grow the count");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.rem |=> count_reg == CNT_W'($past(count_reg) - 1'b1))
        else $error("remove did not shrink the count");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_tready)
        else $error("second command taken before update step");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APPLY |-> $onehot0(eq_v) && $onehot0(rsel_v))
        else $error("more than one cell selected");

endmodule
